// File: rtl/core/m68k_g05_pkg.sv
// types and helpers for the group 0000 / 0101 execute block
// no dependencies
package m68k_g05_pkg;

  typedef struct packed {
    logic [15:0] instr_word;
    logic [31:0] src_value;
    logic [31:0] dst_value;
    logic        dst_is_memory;
    logic        dst_is_data_reg;
    logic [15:0] sr_in;
    logic signed [15:0] displacement;
    logic [31:0] pc_in;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        write_result;
    logic [1:0]  result_size;
    logic [15:0] sr_out;
    logic [31:0] pc_out;
    logic        unhandled;
  } out_word_t;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;

  localparam logic [2:0] OP_OR  = 3'd0;
  localparam logic [2:0] OP_AND = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_ADD = 3'd3;
  localparam logic [2:0] OP_BIT = 3'd4;
  localparam logic [2:0] OP_EOR = 3'd5;
  localparam logic [2:0] OP_CMP = 3'd6;
  localparam logic [2:0] OP_ILL = 3'd7;

  localparam logic [2:0] MODE_AN  = 3'd1;
  localparam logic [2:0] MODE_EXT = 3'd7;

  // operation classes produced by the decoder
  localparam logic [4:0] K_NONE   = 5'd0;
  localparam logic [4:0] K_BIT    = 5'd1;
  localparam logic [4:0] K_SRLOG  = 5'd2;
  localparam logic [4:0] K_IARITH = 5'd3;
  localparam logic [4:0] K_ILOGIC = 5'd4;
  localparam logic [4:0] K_DBCC   = 5'd5;
  localparam logic [4:0] K_SCC    = 5'd6;
  localparam logic [4:0] K_QADDR  = 5'd7;
  localparam logic [4:0] K_QARITH = 5'd8;

  function automatic logic [31:0] sz_mask(input logic [1:0] sz);
    case (sz)
      SZ_BYTE: sz_mask = 32'h0000_00FF;
      SZ_WORD: sz_mask = 32'h0000_FFFF;
      default: sz_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic sz_top(input logic [31:0] v, input logic [1:0] sz);
    case (sz)
      SZ_BYTE: sz_top = v[7];
      SZ_WORD: sz_top = v[15];
      default: sz_top = v[31];
    endcase
  endfunction

  function automatic logic cond_true(input logic [3:0] cc, input logic [15:0] sr);
    logic c, v, z, n;
    c = sr[0]; v = sr[1]; z = sr[2]; n = sr[3];
    case (cc)
      4'd0:  cond_true = 1'b1;
      4'd1:  cond_true = 1'b0;
      4'd2:  cond_true = !c && !z;
      4'd3:  cond_true = c || z;
      4'd4:  cond_true = !c;
      4'd5:  cond_true = c;
      4'd6:  cond_true = !z;
      4'd7:  cond_true = z;
      4'd8:  cond_true = !v;
      4'd9:  cond_true = v;
      4'd10: cond_true = !n;
      4'd11: cond_true = n;
      4'd12: cond_true = n == v;
      4'd13: cond_true = n != v;
      4'd14: cond_true = !z && (n == v);
      default: cond_true = z || (n != v);
    endcase
  endfunction

endpackage

// File: rtl/core/m68k_g05_decode.sv
// stage 1 logic: decodes the opcode word into an operation summary
// depends on m68k_g05_pkg
module m68k_g05_decode
  import m68k_g05_pkg::*;
(
  input  logic [15:0] instr_word,
  input  logic [15:0] sr_in,
  output logic [4:0]  kind,
  output logic        bad,
  output logic        cond
);
  // kind is one of the K_ operation classes from the package
  logic [2:0] f1, mode, rg;
  logic       f2;
  logic [1:0] f3;

  always_comb begin
    f1 = instr_word[11:9];
    f2 = instr_word[8];
    f3 = instr_word[7:6];
    mode = instr_word[5:3];
    rg = instr_word[2:0];
    kind = K_NONE;
    bad = 1'b0;
    cond = cond_true(instr_word[11:8], sr_in);
    if (instr_word[15:12] == 4'h0) begin
      if (f2 || f1 == OP_BIT) begin
        kind = K_BIT;
        if (mode == MODE_AN) bad = 1'b1;
        else if (mode == MODE_EXT) begin
          if (f3 == 2'd0) bad = rg > 3'd4 || (rg == 3'd4 && !f2);
          else bad = rg > 3'd1;
        end
      end else if (f1 == OP_ILL || f3 == 2'd3 || mode == MODE_AN) begin
        bad = 1'b1;
      end else if (mode == MODE_EXT && rg == 3'd4) begin
        kind = K_SRLOG;
        if ((f1 != OP_OR && f1 != OP_AND && f1 != OP_EOR) || f3 == 2'd2) bad = 1'b1;
      end else if (mode == MODE_EXT && rg > 3'd1) begin
        bad = 1'b1;
      end else if (f1 == OP_SUB || f1 == OP_ADD || f1 == OP_CMP) begin
        kind = K_IARITH;
      end else begin
        kind = K_ILOGIC;
      end
    end else if (instr_word[15:12] == 4'h5) begin
      if (f3 == 2'd3) begin
        if (mode == MODE_AN) kind = K_DBCC;
        else if (mode == MODE_EXT && rg > 3'd1) bad = 1'b1;
        else kind = K_SCC;
      end else if ((mode == MODE_EXT && rg > 3'd1) || (mode == MODE_AN && f3 == 2'd0)) begin
        bad = 1'b1;
      end else if (mode == MODE_AN) begin
        kind = K_QADDR;
      end else begin
        kind = K_QARITH;
      end
    end else begin
      bad = 1'b1;
    end
  end

endmodule

// File: rtl/core/m68k_group0_group5_execute.sv
// execute stage for 68000 lines 0000 and 0101
// depends on m68k_g05_pkg and m68k_g05_decode
//
// Usage: the upstream side presents an input word (opcode, fetched operands,
// sr and pc) with in_valid; it is taken at a clock edge where in_stall is low.
// The result word (write-back value and size, new sr, next pc, unhandled flag)
// appears on out_valid and is taken where out_stall is low.
// The stages are decode, compute (one adder plus bit masks), and merge/flag
// assembly, each ending in a register. One word is accepted every cycle while
// in_stall is low; a stage advances when the stage after it is empty or
// advancing, so in_stall is high only while all three stages hold words and
// out_stall is high, and bubbles inside the pipe are squeezed out.
// A stall holds full stages up to the first bubble; none loses or repeats.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
module m68k_group0_group5_execute
  import m68k_g05_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic v1, v2, v3;
  logic adv3, adv2, adv1;

  assign adv3 = !v3 || !out_stall;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall = !adv1;

  // stage 1 registers
  in_word_t   s1;
  logic [4:0] k1;
  logic       b1, c1;
  logic [4:0] k1_next;
  logic       b1_next, c1_next;

  m68k_g05_decode u_dec (
    .instr_word (in_data.instr_word),
    .sr_in      (in_data.sr_in),
    .kind       (k1_next),
    .bad        (b1_next),
    .cond       (c1_next)
  );

  // stage 2: arithmetic and bit masks
  logic [31:0] a_d, a_s, bitm;
  logic        a_sub;
  logic [32:0] a_sum;
  logic [1:0]  sz_c;
  logic [31:0] m2;

  in_word_t    s2;
  logic [4:0]  k2;
  logic        b2, c2;
  logic [32:0] sum2;
  logic [31:0] bit2, as2;
  logic        sub2;
  logic [1:0]  sz2;

  always_comb begin
    sz_c = s1.instr_word[7:6];
    a_sub = 1'b0;
    a_s = s1.src_value;
    if (k1 == K_QADDR || k1 == K_QARITH) begin
      a_s = {28'd0, (s1.instr_word[11:9] == 3'd0), s1.instr_word[11:9]};
      a_sub = s1.instr_word[8];
    end else if (k1 == K_DBCC) begin
      a_s = 32'd1;
      a_sub = 1'b1;
    end else begin
      a_sub = s1.instr_word[11:9] != OP_ADD;
    end
    if (k1 == K_QADDR || k1 == K_DBCC) m2 = 32'hFFFF_FFFF;
    else m2 = sz_mask(sz_c);
    a_d = s1.dst_value & m2;
    a_s = a_s & m2;
    a_sum = a_sub ? ({1'b0, a_d} - {1'b0, a_s}) : ({1'b0, a_d} + {1'b0, a_s});
    if (s1.dst_is_memory) bitm = 32'd1 << s1.src_value[2:0];
    else bitm = 32'd1 << s1.src_value[4:0];
  end

  // stage 3: merge and flags
  logic [31:0] r, rm, mk, res;
  logic        carry, ovf, n, z;
  out_word_t   o_next;

  always_comb begin
    o_next = '0;
    o_next.sr_out = s2.sr_in;
    o_next.pc_out = s2.pc_in;
    mk = sz_mask(sz2);
    r = sum2[31:0] & mk;
    case (sz2)
      SZ_BYTE: carry = sum2[8];
      SZ_WORD: carry = sum2[16];
      default: carry = sum2[32];
    endcase
    if (sub2) ovf = sz_top((as2 ^ s2.dst_value) & (s2.dst_value ^ r), sz2);
    else ovf = sz_top(~(as2 ^ s2.dst_value) & (as2 ^ r), sz2);
    res = 32'd0;
    n = 1'b0;
    z = 1'b0;
    rm = 32'd0;
    case (k2)
      K_BIT: begin
        o_next.sr_out[2] = (s2.dst_value & bit2) == 32'd0;
        if (s2.instr_word[7:6] != 2'd0) begin
          case (s2.instr_word[7:6])
            2'd1:    res = s2.dst_value ^ bit2;
            2'd2:    res = s2.dst_value & ~bit2;
            default: res = s2.dst_value | bit2;
          endcase
          mk = s2.dst_is_memory ? 32'h0000_00FF : 32'hFFFF_FFFF;
          o_next.result_value = (s2.dst_value & ~mk) | (res & mk);
          o_next.write_result = 1'b1;
          o_next.result_size = s2.dst_is_memory ? SZ_BYTE : SZ_LONG;
        end
      end
      K_SRLOG: begin
        rm = (s2.instr_word[7:6] == 2'd0) ? {24'd0, s2.src_value[7:0]}
                                           : {16'd0, s2.src_value[15:0]};
        case (s2.instr_word[11:9])
          OP_OR:   o_next.sr_out = s2.sr_in | rm[15:0];
          OP_EOR:  o_next.sr_out = s2.sr_in ^ rm[15:0];
          default: o_next.sr_out = s2.sr_in &
                     ((s2.instr_word[7:6] == 2'd0) ? (rm[15:0] | 16'hFF00) : rm[15:0]);
        endcase
      end
      K_IARITH, K_QARITH: begin
        n = sz_top(r, sz2);
        z = r == 32'd0;
        o_next.sr_out[3:0] = {n, z, ovf, carry};
        if (k2 == K_IARITH && s2.instr_word[11:9] == OP_CMP) begin
          o_next.result_size = SZ_BYTE;
        end else begin
          o_next.sr_out[4] = carry;
          o_next.result_value = (s2.dst_value & ~mk) | r;
          o_next.write_result = 1'b1;
          o_next.result_size = sz2;
        end
      end
      K_ILOGIC: begin
        case (s2.instr_word[11:9])
          OP_OR:   res = s2.dst_value | s2.src_value;
          OP_AND:  res = s2.dst_value & s2.src_value;
          default: res = s2.dst_value ^ s2.src_value;
        endcase
        o_next.sr_out[3:0] = {sz_top(res, sz2), (res & mk) == 32'd0, 2'b00};
        o_next.result_value = (s2.dst_value & ~mk) | (res & mk);
        o_next.write_result = 1'b1;
        o_next.result_size = sz2;
      end
      K_DBCC: begin
        if (c2) begin
          o_next.pc_out = s2.pc_in + 32'd2;
        end else begin
          o_next.result_value = {s2.dst_value[31:16], sum2[15:0]};
          o_next.write_result = 1'b1;
          o_next.result_size = SZ_WORD;
          if (sum2[15:0] == 16'hFFFF) o_next.pc_out = s2.pc_in + 32'd2;
          else o_next.pc_out = s2.pc_in + {{16{s2.displacement[15]}}, s2.displacement};
        end
      end
      K_SCC: begin
        o_next.result_value = {s2.dst_value[31:8], {8{c2}}};
        o_next.write_result = 1'b1;
      end
      K_QADDR: begin
        o_next.result_value = sum2[31:0];
        o_next.write_result = 1'b1;
        o_next.result_size = SZ_LONG;
      end
      default: ;
    endcase
    if (b2) begin
      o_next = '0;
      o_next.sr_out = s2.sr_in;
      o_next.pc_out = s2.pc_in;
      o_next.unhandled = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1) begin
      s1 <= in_data;
      k1 <= k1_next;
      b1 <= b1_next;
      c1 <= c1_next;
    end
    if (adv2) begin
      s2 <= s1;
      k2 <= k1;
      b2 <= b1;
      c2 <= c1;
      sum2 <= a_sum;
      bit2 <= bitm;
      as2 <= a_s;
      sub2 <= a_sub;
      sz2 <= (k1 == K_QADDR || k1 == K_DBCC) ? SZ_LONG : sz_c;
    end
    if (adv3) out_data <= o_next;
  end

  assign out_valid = v3;

endmodule
